FILE: src/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared widths, token kinds and token record for the source lexer.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int LENGTH_BITS = 16;

  localparam int FIELD_BITS  = 16;
  localparam int KIND_BITS   = 5;

  typedef enum logic [KIND_BITS-1:0] {
    K_INVALID = 5'd0,
    K_END     = 5'd1,
    K_COLON   = 5'd2,
    K_DOT     = 5'd3,
    K_EQUAL   = 5'd4,
    K_BANG    = 5'd5,
    K_BANG_EQ = 5'd6,
    K_PAREN_L = 5'd7,
    K_PAREN_R = 5'd8,
    K_CURLY_L = 5'd9,
    K_CURLY_R = 5'd10,
    K_LT      = 5'd11,
    K_LE      = 5'd12,
    K_GT      = 5'd13,
    K_GE      = 5'd14,
    K_PLUS    = 5'd15,
    K_MINUS   = 5'd16,
    K_STAR    = 5'd17,
    K_SLASH   = 5'd18,
    K_LINE    = 5'd19,
    K_NUMBER  = 5'd20,
    K_NAME    = 5'd21,
    K_DEF     = 5'd22,
    K_FOR     = 5'd23,
    K_AND     = 5'd24,
    K_OR      = 5'd25
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } token_t;

  // Tokens produced by one byte, oldest in tok0.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

FILE: src/slt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_core
// Scanner state and per-byte token decision; up to two tokens per byte.
// ----------------------------------------------------------------------------
module slt_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic [7:0]    byte_in,
  output slt_pkg::push_t push
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_BANG, M_LT, M_GT, M_SLASH, M_COMMENT, M_NUMBER, M_NAME
  } mode_t;

  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  localparam logic [23:0] KW_DEF = 24'h444546;
  localparam logic [23:0] KW_FOR = 24'h464F52;
  localparam logic [23:0] KW_AND = 24'h414E44;
  localparam logic [23:0] KW_OR  = 24'h004F52;

  function automatic kind_t single_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h3A:   k = K_COLON;
      8'h2E:   k = K_DOT;
      8'h3D:   k = K_EQUAL;
      8'h28:   k = K_PAREN_L;
      8'h29:   k = K_PAREN_R;
      8'h7B:   k = K_CURLY_L;
      8'h7D:   k = K_CURLY_R;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, sline_r, sline_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, scol_r, scol_nxt;
  logic [LENGTH_BITS-1:0] run_r, run_nxt;
  logic [23:0]            pre_r, pre_nxt;

  logic [COLUMN_BITS-1:0] col_inc;
  logic [LENGTH_BITS-1:0] run_inc;
  logic                   is_dig, is_let;
  logic                   pend_v, fr_v, do_fresh;
  kind_t                  pend_kind, fr_kind, name_kind, sk;
  logic [LENGTH_BITS-1:0] pend_len;
  logic                   fr_len1;
  token_t                 pend_tok, fr_tok;

  always_comb begin
    col_inc = (col_r < COL_MAX) ? col_r + COLUMN_BITS'(1) : col_r;
    run_inc = (run_r < LEN_MAX) ? run_r + LENGTH_BITS'(1) : run_r;
    is_dig  = (byte_in >= 8'h30) && (byte_in <= 8'h39);
    is_let  = ((byte_in >= 8'h61) && (byte_in <= 8'h7A)) ||
              ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) || (byte_in == 8'h5F);
    sk      = single_kind(byte_in);

    name_kind = K_NAME;
    if (run_r == LENGTH_BITS'(3)) begin
      if (pre_r == KW_DEF) name_kind = K_DEF;
      else if (pre_r == KW_FOR) name_kind = K_FOR;
      else if (pre_r == KW_AND) name_kind = K_AND;
    end else if ((run_r == LENGTH_BITS'(2)) && (pre_r == KW_OR)) begin
      name_kind = K_OR;
    end

    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    run_nxt   = run_r;
    pre_nxt   = pre_r;
    pend_v    = 1'b0;
    pend_kind = K_INVALID;
    pend_len  = LENGTH_BITS'(1);
    do_fresh  = 1'b0;
    fr_v      = 1'b0;
    fr_kind   = K_INVALID;
    fr_len1   = 1'b1;

    unique case (mode_r)
      M_BANG, M_LT, M_GT: begin
        if (byte_in == 8'h3D) begin
          pend_v    = 1'b1;
          pend_kind = (mode_r == M_BANG) ? K_BANG_EQ : (mode_r == M_LT) ? K_LE : K_GE;
          pend_len  = LENGTH_BITS'(2);
          mode_nxt  = M_IDLE;
          col_nxt   = col_inc;
        end else begin
          pend_v    = 1'b1;
          pend_kind = (mode_r == M_BANG) ? K_BANG : (mode_r == M_LT) ? K_LT : K_GT;
          do_fresh  = 1'b1;
        end
      end
      M_SLASH: begin
        if (byte_in == 8'h2F) begin
          mode_nxt = M_COMMENT;
          col_nxt  = col_inc;
        end else begin
          pend_v    = 1'b1;
          pend_kind = K_SLASH;
          do_fresh  = 1'b1;
        end
      end
      M_COMMENT: begin
        if ((byte_in == 8'h0A) || (byte_in == 8'h00)) do_fresh = 1'b1;
        else col_nxt = col_inc;
      end
      M_NUMBER: begin
        if (is_dig) begin
          run_nxt = run_inc;
          col_nxt = col_inc;
        end else begin
          pend_v    = 1'b1;
          pend_kind = K_NUMBER;
          pend_len  = run_r;
          do_fresh  = 1'b1;
        end
      end
      M_NAME: begin
        if (is_let || is_dig) begin
          if (run_r < LENGTH_BITS'(3)) pre_nxt = {pre_r[15:0], byte_in};
          run_nxt = run_inc;
          col_nxt = col_inc;
        end else begin
          pend_v    = 1'b1;
          pend_kind = name_kind;
          pend_len  = run_r;
          do_fresh  = 1'b1;
        end
      end
      M_IDLE: do_fresh = 1'b1;
    endcase

    if (do_fresh) begin
      mode_nxt = M_IDLE;
      if (byte_in == 8'h00) begin
        fr_v      = 1'b1;
        fr_kind   = K_END;
        fr_len1   = 1'b0;
        line_nxt  = LINE_BITS'(1);
        col_nxt   = COLUMN_BITS'(1);
        sline_nxt = LINE_BITS'(1);
        scol_nxt  = COLUMN_BITS'(1);
        run_nxt   = '0;
        pre_nxt   = '0;
      end else if (sk != K_INVALID) begin
        fr_v    = 1'b1;
        fr_kind = sk;
        col_nxt = col_inc;
      end else if ((byte_in == 8'h21) || (byte_in == 8'h3C) ||
                   (byte_in == 8'h3E) || (byte_in == 8'h2F) || is_dig || is_let) begin
        sline_nxt = line_r;
        scol_nxt  = col_r;
        col_nxt   = col_inc;
        if (byte_in == 8'h21) mode_nxt = M_BANG;
        else if (byte_in == 8'h3C) mode_nxt = M_LT;
        else if (byte_in == 8'h3E) mode_nxt = M_GT;
        else if (byte_in == 8'h2F) mode_nxt = M_SLASH;
        else if (is_dig) begin
          mode_nxt = M_NUMBER;
          run_nxt  = LENGTH_BITS'(1);
        end else begin
          mode_nxt = M_NAME;
          run_nxt  = LENGTH_BITS'(1);
          pre_nxt  = {16'h0000, byte_in};
        end
      end else if (byte_in == 8'h0A) begin
        fr_v     = 1'b1;
        fr_kind  = K_LINE;
        line_nxt = (line_r < LINE_MAX) ? line_r + LINE_BITS'(1) : line_r;
        col_nxt  = COLUMN_BITS'(1);
      end else if ((byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0D)) begin
        col_nxt = col_inc;
      end else begin
        fr_v    = 1'b1;
        fr_kind = K_INVALID;
        col_nxt = col_inc;
      end
    end

    pend_tok.kind   = pend_kind;
    pend_tok.line   = FIELD_BITS'(sline_r);
    pend_tok.column = FIELD_BITS'(scol_r);
    pend_tok.length = FIELD_BITS'(pend_len);
    pend_tok.last   = !fr_v;

    fr_tok.kind   = fr_kind;
    fr_tok.line   = FIELD_BITS'(line_r);
    fr_tok.column = FIELD_BITS'(col_r);
    fr_tok.length = fr_len1 ? FIELD_BITS'(1) : '0;
    fr_tok.last   = 1'b1;

    push.count = byte_en ? (2'(pend_v) + 2'(fr_v)) : 2'd0;
    push.tok0  = pend_v ? pend_tok : fr_tok;
    push.tok1  = fr_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      line_r  <= LINE_BITS'(1);
      col_r   <= COLUMN_BITS'(1);
      sline_r <= LINE_BITS'(1);
      scol_r  <= COLUMN_BITS'(1);
      run_r   <= '0;
      pre_r   <= '0;
    end else if (byte_en) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      run_r   <= run_nxt;
      pre_r   <= pre_nxt;
    end
  end

endmodule

FILE: src/slt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_fifo
// Four-entry token queue; takes up to two tokens per cycle, gives one per pop.
// ----------------------------------------------------------------------------
module slt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  slt_pkg::push_t  push,
  input  logic            pop,
  output logic            not_empty,
  output logic            nearly_full,
  output slt_pkg::token_t head
);
  import slt_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  token_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [PTR_BITS-1:0]   wr_ptr_p1;

  always_comb begin
    wr_ptr_p1   = wr_ptr_r + PTR_BITS'(1);
    wr_ptr_nxt  = wr_ptr_r + PTR_BITS'(push.count);
    rd_ptr_nxt  = pop ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt     = cnt_r + CNT_BITS'(push.count) - CNT_BITS'(pop);
    not_empty   = (cnt_r != '0);
    nearly_full = (cnt_r > CNT_BITS'(DEPTH - 2));
    head        = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.count == 2'd2) mem_r[wr_ptr_p1] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: src/source_lexer_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_lexer_tokenizer_unit
// Streaming tokenizer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_byte_in[7:0]
//  out     | output    | out_valid/out_stall| kind, line, column, length, last
//
//  One byte per cycle while in_stall is low; each byte's tokens go into the
//  registered token queue. A byte that closes a pending token and forms one
//  itself gives two tokens; the four-entry token queue sets the stall point.
//  in_stall rises when the queue holds more than two tokens.
//  rst_n is synchronous; state returns to line 1, column 1.
// ----------------------------------------------------------------------------
module source_lexer_tokenizer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [slt_pkg::KIND_BITS-1:0]  out_token_kind,
  output logic [slt_pkg::FIELD_BITS-1:0] out_token_line,
  output logic [slt_pkg::FIELD_BITS-1:0] out_token_column,
  output logic [slt_pkg::FIELD_BITS-1:0] out_token_length,
  output logic                           out_last_of_run
);
  import slt_pkg::*;

  push_t  push;
  token_t head;
  logic   byte_en, nearly_full;

  assign in_stall = nearly_full;
  assign byte_en  = in_valid && !nearly_full;

  slt_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .byte_in (in_byte_in),
    .push    (push)
  );

  slt_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop         (out_valid && !out_stall),
    .not_empty   (out_valid),
    .nearly_full (nearly_full),
    .head        (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_line   = head.line;
  assign out_token_column = head.column;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule
